@@ rtl/gregorian_date_engine_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the date engine checker.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ENGINE_MACROS_SVH
`define GREGORIAN_DATE_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GDE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gde_pkg.sv @@
// ----------------------------------------------------------------------------
// gde_pkg
// Shared constants, types and calendar tables for the date engine.
// ----------------------------------------------------------------------------
package gde_pkg;

    localparam logic [15:0] GDE_MAX_YEAR_DEF = 16'd9999;

    localparam logic [1:0] OP_DAYNUM = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DIFF   = 2'd2;

    localparam int YW  = 14;   // input year width
    localparam int MW  = 4;    // month width
    localparam int DW  = 5;    // day width
    localparam int CW  = 22;   // day count / output day number width
    localparam int SNW = 23;   // internal serial day width
    localparam int RW  = 24;   // serial day plus day count
    localparam int XYW = 16;   // internal result year width

    // floor(y / 100) = (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam int unsigned DAYS_400 = 146097;
    localparam int unsigned DAYS_100 = 36524;
    localparam int unsigned DAYS_4   = 1461;
    localparam int unsigned DAYS_1   = 365;

    typedef struct packed {
        logic            res_ok;
        logic            is_add;
        logic [CW-1:0]   dn;
        logic [CW-1:0]   diff;
        logic [XYW-1:0]  yacc;
        logic [1:0]      q100;
        logic [4:0]      q4;
    } gde_side_t;

    // Days in the months before month m.
    function automatic logic [8:0] gde_cum_days(input logic [MW-1:0] m, input logic leap);
        logic [8:0] c;
        begin
            case (m)
                4'd1:    c = 9'd0;
                4'd2:    c = 9'd31;
                4'd3:    c = 9'd59;
                4'd4:    c = 9'd90;
                4'd5:    c = 9'd120;
                4'd6:    c = 9'd151;
                4'd7:    c = 9'd181;
                4'd8:    c = 9'd212;
                4'd9:    c = 9'd243;
                4'd10:   c = 9'd273;
                4'd11:   c = 9'd304;
                4'd12:   c = 9'd334;
                default: c = 9'd0;
            endcase
            if (leap && (m > 4'd2) && (m <= 4'd12))
            begin
                c = c + 9'd1;
            end
            return c;
        end
    endfunction

    function automatic logic [DW-1:0] gde_month_len(input logic [MW-1:0] m, input logic leap);
        logic [DW-1:0] l;
        begin
            case (m) inside
                4'd2:                    l = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: l = 5'd30;
                default:                 l = 5'd31;
            endcase
            return l;
        end
    endfunction

endpackage

@@ rtl/gde_daynum.sv @@
// ----------------------------------------------------------------------------
// gde_daynum
// Three-stage date check and serial day number of one date.
// ----------------------------------------------------------------------------
module gde_daynum import gde_pkg::*; #(
    parameter logic [15:0] MAX_YEAR = GDE_MAX_YEAR_DEF
) (
    input  logic            clk,
    input  logic            en,
    input  logic [YW-1:0]   year,
    input  logic [MW-1:0]   month,
    input  logic [DW-1:0]   day,
    output logic            ok,
    output logic [SNW-1:0]  dn
);

    localparam int PRW = YW + 13;

    // stage 1: year / 100
    logic [PRW-1:0] yprod;
    logic [YW-1:0]  y1_reg;
    logic [MW-1:0]  m1_reg;
    logic [DW-1:0]  d1_reg;
    logic [7:0]     yq1_reg;

    assign yprod = PRW'(year) * PRW'(DIV100_MUL);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg  <= year;
            m1_reg  <= month;
            d1_reg  <= day;
            yq1_reg <= yprod[DIV100_SHIFT +: 8];
        end
    end

    // stage 2: leap rule, validity, partial sums
    logic [YW:0]     yq100;
    logic            div100;
    logic            leap;
    logic [DW-1:0]   mlen;
    logic [YW-1:0]   p;
    logic [7:0]      p100;
    logic            ok2_next;
    logic [SNW-1:0]  t1_next;
    logic [9:0]      t2_next;
    logic            ok2_reg;
    logic [SNW-1:0]  t1_reg;
    logic [9:0]      t2_reg;
    logic [7:0]      p100_reg;

    always_comb
    begin
        yq100    = (YW+1)'(yq1_reg) * (YW+1)'(100);
        div100   = (yq100 == {1'b0, y1_reg});
        leap     = (y1_reg[1:0] == 2'd0) && (!div100 || (yq1_reg[1:0] == 2'd0));
        mlen     = gde_month_len(m1_reg, leap);
        ok2_next = (y1_reg != '0) && ({2'b00, y1_reg} <= MAX_YEAR)
                   && (m1_reg >= 4'd1) && (m1_reg <= 4'd12)
                   && (d1_reg != '0) && (d1_reg <= mlen);
        p        = y1_reg - YW'(1);
        p100     = yq1_reg - 8'(div100);
        t1_next  = SNW'(p) * SNW'(365) + SNW'(p >> 2);
        t2_next  = 10'(p100 >> 2) + 10'(gde_cum_days(m1_reg, leap)) + 10'(d1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok2_reg  <= ok2_next;
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            p100_reg <= p100;
        end
    end

    // stage 3: final sum
    logic            ok3_reg;
    logic [SNW-1:0]  dn3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok3_reg <= ok2_reg;
            dn3_reg <= t1_reg + SNW'(t2_reg) - SNW'(p100_reg);
        end
    end

    assign ok = ok3_reg;
    assign dn = dn3_reg;

endmodule

@@ rtl/gde_cdiv.sv @@
// ----------------------------------------------------------------------------
// gde_cdiv
// Two-stage divide by a constant: reciprocal estimate, then one correction.
// ----------------------------------------------------------------------------
module gde_cdiv import gde_pkg::*; #(
    parameter int          W  = 24,
    parameter int unsigned D  = 146097,
    parameter int          QW = 7
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  logic [W-1:0]   x,
    input  gde_side_t      in_side,
    output logic           out_vld,
    output logic [QW-1:0]  q,
    output logic [W-1:0]   rem,
    output gde_side_t      out_side
);

    localparam int              PW = 2 * W;
    localparam longint unsigned K  = (64'd1 << W) / D;

    // stage A: estimate, low by at most one
    logic [PW-1:0] prod;
    logic          vld_a_reg;
    logic [W-1:0]  x_a_reg;
    logic [QW-1:0] est_a_reg;
    gde_side_t     side_a_reg;

    assign prod = PW'(x) * PW'(K);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_a_reg    <= x;
            est_a_reg  <= QW'(prod[PW-1:W]);
            side_a_reg <= in_side;
        end
    end

    // stage B: remainder and correction
    logic [W-1:0]  sub;
    logic [QW-1:0] q_next;
    logic [W-1:0]  rem_next;
    logic          vld_b_reg;
    logic [QW-1:0] q_b_reg;
    logic [W-1:0]  rem_b_reg;
    gde_side_t     side_b_reg;

    always_comb
    begin
        sub = x_a_reg - W'(est_a_reg) * W'(D);
        if (sub >= W'(D))
        begin
            q_next   = est_a_reg + QW'(1);
            rem_next = sub - W'(D);
        end
        else
        begin
            q_next   = est_a_reg;
            rem_next = sub;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_b_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_b_reg    <= q_next;
            rem_b_reg  <= rem_next;
            side_b_reg <= side_a_reg;
        end
    end

    assign out_vld  = vld_b_reg;
    assign q        = q_b_reg;
    assign rem      = rem_b_reg;
    assign out_side = side_b_reg;

endmodule

@@ rtl/gregorian_date_engine.sv @@
// Throughput: one beat per cycle; the 14-stage pipeline moves as one and
// holds whole while the output beat waits for out_ready.
// Reset: rst_n clears every stage valid bit at once; the block takes a
// beat as soon as rst_n is released.
// ----------------------------------------------------------------------------
// gregorian_date_engine
// Proleptic Gregorian calendar engine: day number, add days, day difference.
// ----------------------------------------------------------------------------
module gregorian_date_engine import gde_pkg::*; #(
    parameter logic [15:0] MAX_YEAR = GDE_MAX_YEAR_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      opcode,
    input  logic [YW-1:0]   first_year,
    input  logic [MW-1:0]   first_month,
    input  logic [DW-1:0]   first_day,
    input  logic [YW-1:0]   second_year,
    input  logic [MW-1:0]   second_month,
    input  logic [DW-1:0]   second_day,
    input  logic [CW-1:0]   day_count,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            valid_res,
    output logic [CW-1:0]   day_number,
    output logic [YW-1:0]   result_year,
    output logic [MW-1:0]   result_month,
    output logic [DW-1:0]   result_day,
    output logic [CW-1:0]   difference,
    output logic            overflow
);

    // One enable for the whole pipeline: advance unless the output beat
    // is stuck. Each stage carries its own valid bit, so bubbles flow.
    logic en;
    logic out_vld_reg;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Stages 1-3: day number of both dates, side data delayed alongside
    // ------------------------------------------------------------------
    logic            ok1;
    logic            ok2;
    logic [SNW-1:0]  dn1;
    logic [SNW-1:0]  dn2;

    gde_daynum #(.MAX_YEAR(MAX_YEAR)) u_first (
        .clk   (clk),
        .en    (en),
        .year  (first_year),
        .month (first_month),
        .day   (first_day),
        .ok    (ok1),
        .dn    (dn1)
    );

    gde_daynum #(.MAX_YEAR(MAX_YEAR)) u_second (
        .clk   (clk),
        .en    (en),
        .year  (second_year),
        .month (second_month),
        .day   (second_day),
        .ok    (ok2),
        .dn    (dn2)
    );

    logic [2:0]     vld_dn_reg;
    logic [1:0]     op_reg  [3];
    logic [CW-1:0]  cnt_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_dn_reg <= '0;
        end
        else if (en)
        begin
            vld_dn_reg <= {vld_dn_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0]  <= opcode;
            op_reg[1]  <= op_reg[0];
            op_reg[2]  <= op_reg[1];
            cnt_reg[0] <= day_count;
            cnt_reg[1] <= cnt_reg[0];
            cnt_reg[2] <= cnt_reg[1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: decide validity, form the difference and the zero-based
    // target day for the add path
    // ------------------------------------------------------------------
    logic            res_ok;
    logic [SNW-1:0]  adiff;
    gde_side_t       side4_next;
    logic            vld4_reg;
    logic [RW-1:0]   r4_reg;
    gde_side_t       side4_reg;

    always_comb
    begin
        res_ok = (op_reg[2] <= OP_DIFF) && ok1 && ((op_reg[2] != OP_DIFF) || ok2);
        adiff  = (dn1 >= dn2) ? (dn1 - dn2) : (dn2 - dn1);
        side4_next        = '0;
        side4_next.res_ok = res_ok;
        side4_next.is_add = (op_reg[2] == OP_ADD);
        side4_next.dn     = res_ok ? CW'(dn1) : '0;
        side4_next.diff   = (res_ok && (op_reg[2] == OP_DIFF)) ? CW'(adiff) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld4_reg <= vld_dn_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r4_reg    <= RW'(dn1) + RW'(cnt_reg[2]) - RW'(1);
            side4_reg <= side4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 5-12: peel off 400-year, 100-year, 4-year and 1-year cycles.
    // The 100-year and 1-year quotients clamp at 3 (last day of a cycle).
    // ------------------------------------------------------------------
    logic            v_d1;
    logic [6:0]      q_d1;
    logic [RW-1:0]   r_d1;
    gde_side_t       s_d1;
    gde_side_t       s_d1_fix;

    gde_cdiv #(.W(RW), .D(DAYS_400), .QW(7)) u_div400 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld4_reg),
        .x        (r4_reg),
        .in_side  (side4_reg),
        .out_vld  (v_d1),
        .q        (q_d1),
        .rem      (r_d1),
        .out_side (s_d1)
    );

    always_comb
    begin
        s_d1_fix      = s_d1;
        s_d1_fix.yacc = XYW'(q_d1) * XYW'(400);
    end

    logic            v_d2;
    logic [2:0]      q_d2;
    logic [17:0]     r_d2;
    gde_side_t       s_d2;
    gde_side_t       s_d2_fix;
    logic [1:0]      q100c;
    logic [15:0]     r2c;

    gde_cdiv #(.W(18), .D(DAYS_100), .QW(3)) u_div100 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v_d1),
        .x        (18'(r_d1)),
        .in_side  (s_d1_fix),
        .out_vld  (v_d2),
        .q        (q_d2),
        .rem      (r_d2),
        .out_side (s_d2)
    );

    always_comb
    begin
        if (q_d2 >= 3'd4)
        begin
            q100c = 2'd3;
            r2c   = 16'(r_d2) + 16'(DAYS_100);
        end
        else
        begin
            q100c = 2'(q_d2);
            r2c   = 16'(r_d2);
        end
        s_d2_fix      = s_d2;
        s_d2_fix.q100 = q100c;
        s_d2_fix.yacc = s_d2.yacc + XYW'(q100c) * XYW'(100);
    end

    logic            v_d3;
    logic [5:0]      q_d3;
    logic [15:0]     r_d3;
    gde_side_t       s_d3;
    gde_side_t       s_d3_fix;

    gde_cdiv #(.W(16), .D(DAYS_4), .QW(6)) u_div4 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v_d2),
        .x        (r2c),
        .in_side  (s_d2_fix),
        .out_vld  (v_d3),
        .q        (q_d3),
        .rem      (r_d3),
        .out_side (s_d3)
    );

    always_comb
    begin
        s_d3_fix      = s_d3;
        s_d3_fix.q4   = 5'(q_d3);
        s_d3_fix.yacc = s_d3.yacc + (XYW'(q_d3) << 2);
    end

    logic            v_d4;
    logic [2:0]      q_d4;
    logic [10:0]     r_d4;
    gde_side_t       s_d4;

    gde_cdiv #(.W(11), .D(DAYS_1), .QW(3)) u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v_d3),
        .x        (11'(r_d3)),
        .in_side  (s_d3_fix),
        .out_vld  (v_d4),
        .q        (q_d4),
        .rem      (r_d4),
        .out_side (s_d4)
    );

    // ------------------------------------------------------------------
    // Stage 13: year and leap flag. The year is leap exactly when it is the
    // last of its 4-year cycle, unless that cycle ends a plain century.
    // ------------------------------------------------------------------
    logic [1:0]      q1c;
    logic [8:0]      doy;
    logic            vld13_reg;
    logic [XYW-1:0]  year13_reg;
    logic            leap13_reg;
    logic [8:0]      doy13_reg;
    gde_side_t       side13_reg;

    always_comb
    begin
        if (q_d4 >= 3'd4)
        begin
            q1c = 2'd3;
            doy = 9'(DAYS_1);
        end
        else
        begin
            q1c = 2'(q_d4);
            doy = 9'(r_d4);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld13_reg <= 1'b0;
        end
        else if (en)
        begin
            vld13_reg <= v_d4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            year13_reg <= s_d4.yacc + XYW'(q1c) + XYW'(1);
            leap13_reg <= (q1c == 2'd3) && ((s_d4.q4 != 5'd24) || (s_d4.q100 == 2'd3));
            doy13_reg  <= doy;
            side13_reg <= s_d4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 14: month and day from day of year, saturate, output register
    // ------------------------------------------------------------------
    logic [MW-1:0]  mon;
    logic [8:0]     dday;
    logic           sat;
    logic           add_ok;
    logic [YW-1:0]  ry_next;
    logic [MW-1:0]  rm_next;
    logic [DW-1:0]  rd_next;

    always_comb
    begin
        mon = 4'd1;
        for (int i = 2; i <= 12; i++)
        begin
            if (doy13_reg >= gde_cum_days(MW'(i), leap13_reg))
            begin
                mon = MW'(i);
            end
        end
        dday   = doy13_reg - gde_cum_days(mon, leap13_reg) + 9'd1;
        sat    = (year13_reg > MAX_YEAR);
        add_ok = side13_reg.res_ok && side13_reg.is_add;
        if (!add_ok)
        begin
            ry_next = '0;
            rm_next = '0;
            rd_next = '0;
        end
        else if (sat)
        begin
            ry_next = YW'(MAX_YEAR);
            rm_next = 4'd12;
            rd_next = 5'd31;
        end
        else
        begin
            ry_next = YW'(year13_reg);
            rm_next = mon;
            rd_next = DW'(dday);
        end
    end

    logic            vres_reg;
    logic [CW-1:0]   dn_out_reg;
    logic [YW-1:0]   ry_reg;
    logic [MW-1:0]   rm_reg;
    logic [DW-1:0]   rd_reg;
    logic [CW-1:0]   diff_reg;
    logic            ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld13_reg;
        end
    end

    // Hold the beat while it is valid and out_ready is low; en covers every stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vres_reg   <= side13_reg.res_ok;
            dn_out_reg <= side13_reg.dn;
            ry_reg     <= ry_next;
            rm_reg     <= rm_next;
            rd_reg     <= rd_next;
            diff_reg   <= side13_reg.diff;
            ovf_reg    <= add_ok && sat;
        end
    end

    assign out_valid    = out_vld_reg;
    assign valid_res    = vres_reg;
    assign day_number   = dn_out_reg;
    assign result_year  = ry_reg;
    assign result_month = rm_reg;
    assign result_day   = rd_reg;
    assign difference   = diff_reg;
    assign overflow     = ovf_reg;

endmodule

@@ rtl/gde_checker.sv @@
// ----------------------------------------------------------------------------
// gde_checker
// Port-level checks on the date engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "gregorian_date_engine_macros.svh"

module gde_checker import gde_pkg::*; (
    input logic            clk,
    input logic            rst_n,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic            valid_res,
    input logic [CW-1:0]   day_number,
    input logic [YW-1:0]   result_year,
    input logic [MW-1:0]   result_month,
    input logic [DW-1:0]   result_day,
    input logic [CW-1:0]   difference,
    input logic            overflow
);

    `GDE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(day_number) && $stable(difference) && $stable(result_year), "output beat changed while stalled")
    `GDE_ASSERT_NOW(a_stall_back, out_valid && !out_ready, !in_ready, "input taken while output stalled")
    `GDE_ASSERT_NOW(a_invalid_zero, out_valid && !valid_res, (day_number == '0) && (difference == '0) && (result_year == '0) && !overflow, "invalid result carries data")
    `GDE_ASSERT_NOW(a_ovf_sat, out_valid && overflow, valid_res && (result_month == 4'd12) && (result_day == 5'd31), "overflow without saturated date")
    `GDE_ASSERT_NOW(a_op_excl, out_valid && (difference != '0), (result_year == '0) && !overflow, "difference and added date both set")

endmodule

bind gregorian_date_engine gde_checker u_gde_checker (.*);
